/* src/srts_pkg.sv */
package srts_pkg;

	localparam int ID_W    = 32;
	localparam int NAME_W  = 64;
	localparam int SCORE_W = 16;
	localparam int RANK_W  = 7;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_ROTATE,
		OP_SHIFT
	} op_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RANK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic               valid;
		logic [ID_W-1:0]    id;
		logic [NAME_W-1:0]  name;
		logic [SCORE_W-1:0] score;
		logic [RANK_W-1:0]  cnt;
	} rec_t;

	typedef struct packed {
		op_t                op;
		logic [ID_W-1:0]    id;
		logic [NAME_W-1:0]  name;
		logic [SCORE_W-1:0] score;
		logic               bc_valid;
		logic [SCORE_W-1:0] bc_score;
	} ctrl_t;

endpackage

/* src/score_rank_then_id_sort.sv */
// Competition ranking with identifier sort.
// Slave stream s_axis: one record per item (id, packed name, score), tlast
// marks the final record of a set. Master stream m_axis: one result per
// stored record (id, name, score, rank) in ascending id order, equal ids in
// arrival order, tlast on the final result.
// Records enter a chain of MAX_RECORDS cells kept sorted by id; one record is
// taken every cycle while loading. A record arriving with the chain full is
// dropped, though its tlast still closes the set.
// After the last record, the chain rotates through all MAX_RECORDS cells
// while the score at the head is broadcast, so each record counts the
// strictly higher scores. Then the chain drains from the head, one result
// per cycle while m_axis_tready is high, into an output register; the first
// result is valid once the rotation is done and the head is registered.
// s_axis_tready is low from the last record until the chain has drained.
// If m_axis_tready is low, the chain holds and nothing is lost.
// Reset empties the chain and the output register and returns to loading.
module score_rank_then_id_sort #(
	parameter int MAX_RECORDS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,  // student_id[31:0], student_name[95:32], score[111:96]
	input  logic         s_axis_tlast,  // last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata,  // out_id[31:0], out_name[95:32], out_score[111:96],
	                                    // rank[118:112], zero[119]
	output logic         m_axis_tlast   // out_last
);

	localparam int PW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

	srts_pkg::state_t state_q, state_d;
	logic [PW-1:0]    ph_q, ph_d;
	srts_pkg::ctrl_t  ctrl;
	srts_pkg::rec_t   cells [MAX_RECORDS];
	logic             mv    [MAX_RECORDS];
	logic             in_acc;
	logic             take;
	logic             full;

	logic                        m_valid_q;
	logic                        m_last_q;
	logic [srts_pkg::ID_W-1:0]   m_id_q;
	logic [srts_pkg::NAME_W-1:0] m_name_q;
	logic [srts_pkg::SCORE_W-1:0] m_score_q;
	logic [srts_pkg::RANK_W-1:0] m_rank_q;

	assign full          = cells[MAX_RECORDS-1].valid;
	assign s_axis_tready = (state_q == srts_pkg::ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign take          = (state_q == srts_pkg::ST_DRAIN) && cells[0].valid &&
	                       (!m_valid_q || m_axis_tready);

	always_comb begin
		state_d       = state_q;
		ph_d          = ph_q;
		ctrl.op       = srts_pkg::OP_HOLD;
		ctrl.id       = s_axis_tdata[31:0];
		ctrl.name     = s_axis_tdata[95:32];
		ctrl.score    = s_axis_tdata[111:96];
		ctrl.bc_valid = cells[0].valid;
		ctrl.bc_score = cells[0].score;
		unique case (state_q)
			srts_pkg::ST_LOAD: begin
				if (in_acc) begin
					if (!full) begin
						ctrl.op = srts_pkg::OP_INSERT;
					end
					if (s_axis_tlast) begin
						state_d = srts_pkg::ST_RANK;
						ph_d    = '0;
					end
				end
			end
			srts_pkg::ST_RANK: begin
				ctrl.op = srts_pkg::OP_ROTATE;
				ph_d    = ph_q + 1'b1;
				if (ph_q == PW'(MAX_RECORDS - 1)) begin
					state_d = srts_pkg::ST_DRAIN;
				end
			end
			srts_pkg::ST_DRAIN: begin
				if (take) begin
					ctrl.op = srts_pkg::OP_SHIFT;
					if (!cells[1].valid) begin
						state_d = srts_pkg::ST_LOAD;
					end
				end
			end
			default: begin
				state_d = srts_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srts_pkg::ST_LOAD;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
			srts_pkg::rec_t lrec;
			srts_pkg::rec_t rrec;
			logic           lmv;
			if (gi == 0) begin : g_head
				assign lrec = '0;
				assign lmv  = 1'b0;
			end else begin : g_body
				assign lrec = cells[gi-1];
				assign lmv  = mv[gi-1];
			end
			if (gi == MAX_RECORDS - 1) begin : g_tail
				// rotation wraps the head around; a drain shifts in an empty cell
				always_comb begin
					rrec = cells[0];
					if (ctrl.op == srts_pkg::OP_SHIFT) begin
						rrec.valid = 1'b0;
					end
				end
			end else begin : g_mid
				assign rrec = cells[gi+1];
			end
			srts_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.left       (lrec),
				.left_moves (lmv),
				.right      (rrec),
				.cur        (cells[gi]),
				.moves      (mv[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (take) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_id_q    <= cells[0].id;
			m_name_q  <= cells[0].name;
			m_score_q <= cells[0].score;
			m_rank_q  <= cells[0].cnt + 1'b1;
			m_last_q  <= !cells[1].valid;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_rank_q, m_score_q, m_name_q, m_id_q};
	assign m_axis_tlast  = m_last_q;

endmodule

/* src/srts_cell.sv */
module srts_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  srts_pkg::ctrl_t ctrl,
	input  srts_pkg::rec_t  left,
	input  logic            left_moves,
	input  srts_pkg::rec_t  right,
	output srts_pkg::rec_t  cur,
	output logic            moves
);

	logic                         valid_q;
	logic [srts_pkg::ID_W-1:0]    id_q;
	logic [srts_pkg::NAME_W-1:0]  name_q;
	logic [srts_pkg::SCORE_W-1:0] score_q;
	logic [srts_pkg::RANK_W-1:0]  cnt_q;
	srts_pkg::rec_t               rec;
	srts_pkg::rec_t               nxt;
	logic                         inc;

	assign rec   = {valid_q, id_q, name_q, score_q, cnt_q};
	assign cur   = rec;
	// this cell sits at or past the insertion point (stable: equal ids stay)
	assign moves = !rec.valid || (rec.id > ctrl.id);
	assign inc   = ctrl.bc_valid && right.valid && (ctrl.bc_score > right.score);

	always_comb begin
		nxt = rec;
		unique case (ctrl.op)
			srts_pkg::OP_HOLD: begin
				nxt = rec;
			end
			srts_pkg::OP_INSERT: begin
				if (moves) begin
					if (left_moves) begin
						nxt = left;
					end else begin
						nxt.valid = 1'b1;
						nxt.id    = ctrl.id;
						nxt.name  = ctrl.name;
						nxt.score = ctrl.score;
						nxt.cnt   = '0;
					end
				end
			end
			srts_pkg::OP_ROTATE: begin
				nxt     = right;
				nxt.cnt = right.cnt + {{(srts_pkg::RANK_W-1){1'b0}}, inc};
			end
			srts_pkg::OP_SHIFT: begin
				nxt = right;
			end
			default: begin
				nxt = rec;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q    <= nxt.id;
		name_q  <= nxt.name;
		score_q <= nxt.score;
		cnt_q   <= nxt.cnt;
	end

endmodule
